// File: hdl/frs_pkg.sv
// Shared types, constants and the CRC step function for the fragment reassembler.
`default_nettype none
package frs_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int STORE_BYTES = 1024;
	localparam int COUNT_LIMIT = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] CRC_INIT = 16'hffff;
	localparam logic [15:0] CRC_TOP = 16'h8000;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [2:0] ST_REJECT = 3'd0;
	localparam logic [2:0] ST_STORED = 3'd1;
	localparam logic [2:0] ST_COMPLETE = 3'd2;
	localparam logic [2:0] ST_CRC_FAIL = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;

	localparam logic [1:0] REG_MAGIC_FIRST = 2'd0;
	localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
	localparam logic [1:0] REG_FORMAT_VERSION = 2'd2;

	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       frame_end;
		logic [9:0] read_index;
	} in_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [10:0] packet_length;
		logic [31:0] sender;
		logic [31:0] packet_id;
		logic [7:0]  read_data;
	} result_t;

	typedef enum logic [1:0] {
		CMD_READ,
		CMD_REJECT,
		CMD_FRAME
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [9:0]  read_index;
		logic [5:0]  idx;
		logic [6:0]  cnt;
		logic [7:0]  plen;
		logic [10:0] off;
		logic [31:0] sender;
		logic [31:0] packet_id;
		logic [15:0] check;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ_WAIT,
		BK_COPY,
		BK_TALLY,
		BK_CRC,
		BK_CHECK
	} back_state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		r = c ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if ((r & CRC_TOP) != 16'h0000) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/frs_queue.sv
// Two-entry command queue between the intake front end and the assembly back end.
`default_nettype none
module frs_queue
	import frs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      valid,
	output logic      full,
	output cmd_t      head
);

	cmd_t       entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign valid = (count_q != 2'd0);
	assign full = (count_q == 2'(QUEUE_DEPTH));
	assign head = entry_q[rd_ptr_q];

endmodule
`default_nettype wire

// File: hdl/frs_front.sv
// Intake front end: configuration registers, frame staging and frame validation.
`default_nettype none
module frs_front
	import frs_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 64,
	parameter int MAX_PIECES = 16,
	localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_wdata,
	input  wire logic          accept,
	input  wire in_req_t       req,
	input  wire logic          frame_done,
	input  wire logic [PW-1:0] buf_raddr,
	output logic [7:0]         buf_rdata,
	output logic               push,
	output cmd_t               push_cmd,
	output logic               hold
);

	localparam int STAGE = HEADER_BYTES + PAYLOAD_BYTES;
	localparam int CW = $clog2(STAGE + 2);

	logic [7:0]    magic_first_q;
	logic [7:0]    magic_second_q;
	logic [7:0]    format_version_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW-1:0] flen_s1;
	logic          check_s1;
	logic          hold_q;
	logic [7:0]    hdr_q [HEADER_BYTES];
	logic [7:0]    pay_mem [PAYLOAD_BYTES];
	logic          frame_byte;

	logic [9:0]    flen10;
	logic [7:0]    idx;
	logic [7:0]    cnt;
	logic [7:0]    plen;
	logic [15:0]   off_full;
	logic [16:0]   end_full;
	logic          frame_ok;
	cmd_t          frame_cmd;

	assign frame_byte = accept && (req.req_type == REQ_FRAME);
	assign count_next = (count_q <= CW'(STAGE)) ? count_q + CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q <= 8'h00;
			magic_second_q <= 8'h00;
			format_version_q <= 8'h00;
			count_q <= '0;
			check_s1 <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAGIC_FIRST: magic_first_q <= cfg_wdata;
					REG_MAGIC_SECOND: magic_second_q <= cfg_wdata;
					REG_FORMAT_VERSION: format_version_q <= cfg_wdata;
					default: ;
				endcase
			end
			check_s1 <= frame_byte && req.frame_end;
			if (frame_byte) begin
				count_q <= req.frame_end ? '0 : count_next;
			end
			if (frame_byte && req.frame_end) begin
				hold_q <= 1'b1;
			end else if (frame_done) begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_byte && req.frame_end) begin
			flen_s1 <= count_next;
		end
		if (frame_byte && (count_q < CW'(HEADER_BYTES))) begin
			hdr_q[count_q[3:0]] <= req.data_byte;
		end
		if (frame_byte && (count_q >= CW'(HEADER_BYTES)) && (count_q < CW'(STAGE))) begin
			pay_mem[PW'(count_q - CW'(HEADER_BYTES))] <= req.data_byte;
		end
		buf_rdata <= pay_mem[buf_raddr];
	end

	always_comb begin
		flen10 = 10'(flen_s1);
		idx = hdr_q[3];
		cnt = hdr_q[4];
		plen = hdr_q[5];
		off_full = 16'(idx) * 16'(PAYLOAD_BYTES);
		end_full = 17'(off_full) + 17'(plen);
		frame_ok = (flen10 >= 10'(HEADER_BYTES)) && (flen10 <= 10'(STAGE)) &&
			(hdr_q[0] == magic_first_q) && (hdr_q[1] == magic_second_q) &&
			(hdr_q[2] == format_version_q) && (cnt != 8'd0) &&
			(cnt <= 8'(MAX_PIECES)) && (9'(cnt) <= 9'(COUNT_LIMIT)) && (idx < cnt) &&
			(plen <= 8'(PAYLOAD_BYTES)) && (flen10 == 10'(plen) + 10'(HEADER_BYTES)) &&
			(end_full <= 17'(STORE_BYTES));
		frame_cmd.kind = frame_ok ? CMD_FRAME : CMD_REJECT;
		frame_cmd.read_index = 10'd0;
		frame_cmd.idx = idx[5:0];
		frame_cmd.cnt = cnt[6:0];
		frame_cmd.plen = plen;
		frame_cmd.off = off_full[10:0];
		frame_cmd.sender = {hdr_q[9], hdr_q[8], hdr_q[7], hdr_q[6]};
		frame_cmd.packet_id = {hdr_q[13], hdr_q[12], hdr_q[11], hdr_q[10]};
		frame_cmd.check = {hdr_q[15], hdr_q[14]};
		if (check_s1) begin
			push = 1'b1;
			push_cmd = frame_cmd;
		end else begin
			push = accept && (req.req_type == REQ_READ);
			push_cmd = frame_cmd;
			push_cmd.kind = CMD_READ;
			push_cmd.read_index = req.read_index;
		end
	end

	assign hold = hold_q;

endmodule
`default_nettype wire

// File: hdl/frs_back.sv
// Assembly back end: packet store, fragment commit, completion CRC pass and read-back.
`default_nettype none
module frs_back
	import frs_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 64,
	parameter int MAX_PIECES = 16,
	localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire cmd_t          q_cmd,
	input  wire logic [7:0]    buf_rdata,
	output logic               pop,
	output logic [PW-1:0]      buf_raddr,
	output logic               frame_done,
	output logic               done,
	output result_t            result
);

	localparam int SPAN = MAX_PIECES * PAYLOAD_BYTES;
	localparam int CLEAR_LEN = (SPAN < STORE_BYTES) ? SPAN : STORE_BYTES;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [10:0]           addr_q;
	logic                  clear_to_copy_q;
	logic                  full_clear_q;
	cmd_t                  cmd_q;
	logic [31:0]           cur_sender_q;
	logic [31:0]           cur_pid_q;
	logic [15:0]           cur_chk_q;
	logic [6:0]            exp_q;
	logic [MAX_PIECES-1:0] rcvd_q;
	logic [7:0]            fpl_q;
	logic [15:0]           crc_q;
	logic [10:0]           total_q;
	logic                  copy_v_s1;
	logic [9:0]            copy_a_s1;
	logic                  crc_v_s1;
	logic                  done_q;
	result_t               result_q;

	logic [7:0]            store_mem [STORE_BYTES];
	logic [7:0]            mem_rdata;
	logic                  mem_we;
	logic [9:0]            mem_waddr;
	logic [7:0]            mem_wdata;
	logic [9:0]            mem_raddr;

	logic                  new_assembly;
	logic [MAX_PIECES-1:0] rcvd_new;
	logic [MAX_PIECES-1:0] full_mask;
	logic [7:0]            fpl_new;
	logic                  complete;
	logic [10:0]           total_new;

	assign new_assembly = (q_cmd.sender != cur_sender_q) || (q_cmd.packet_id != cur_pid_q) ||
		(q_cmd.check != cur_chk_q) || (q_cmd.cnt != exp_q);

	always_comb begin
		rcvd_new = rcvd_q | (MAX_PIECES'(1) << cmd_q.idx);
		fpl_new = ((cmd_q.idx + 6'd1) == cmd_q.cnt[5:0] || (cmd_q.cnt == 7'd64 && cmd_q.idx == 6'd63))
			? cmd_q.plen : fpl_q;
		for (int i = 0; i < MAX_PIECES; i++) begin
			full_mask[i] = (7'(i) < cmd_q.cnt);
		end
		complete = (rcvd_new == full_mask) && (fpl_new != 8'd0);
		total_new = 11'((11'(cmd_q.cnt) - 11'd1) * 11'(PAYLOAD_BYTES)) + 11'(fpl_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		frame_done = 1'b0;
		mem_we = 1'b0;
		mem_waddr = addr_q[9:0];
		mem_wdata = 8'h00;
		mem_raddr = addr_q[9:0];
		buf_raddr = PW'(addr_q);
		case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == (full_clear_q ? 11'(STORE_BYTES - 1) : 11'(CLEAR_LEN - 1))) begin
					state_d = clear_to_copy_q ? BK_COPY : BK_IDLE;
				end
			end
			BK_IDLE: begin
				mem_raddr = q_cmd.read_index;
				if (q_valid) begin
					pop = 1'b1;
					case (q_cmd.kind)
						CMD_READ: state_d = BK_READ_WAIT;
						CMD_FRAME: state_d = new_assembly ? BK_CLEAR : BK_COPY;
						default: frame_done = 1'b1;
					endcase
				end
			end
			BK_READ_WAIT: state_d = BK_IDLE;
			BK_COPY: begin
				if (copy_v_s1) begin
					mem_we = 1'b1;
					mem_waddr = copy_a_s1;
					mem_wdata = buf_rdata;
				end
				if (addr_q == 11'(cmd_q.plen)) begin
					state_d = BK_TALLY;
				end
			end
			BK_TALLY: begin
				if (copy_v_s1) begin
					mem_we = 1'b1;
					mem_waddr = copy_a_s1;
					mem_wdata = buf_rdata;
				end
				if (complete) begin
					state_d = BK_CRC;
				end else begin
					state_d = BK_IDLE;
					frame_done = 1'b1;
				end
			end
			BK_CRC: begin
				if (addr_q == total_q) begin
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				state_d = BK_CLEAR;
				frame_done = 1'b1;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= store_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 11'd0;
			clear_to_copy_q <= 1'b0;
			full_clear_q <= 1'b1;
			cur_sender_q <= 32'd0;
			cur_pid_q <= 32'd0;
			cur_chk_q <= 16'd0;
			exp_q <= 7'd0;
			rcvd_q <= '0;
			fpl_q <= 8'd0;
			copy_v_s1 <= 1'b0;
			crc_v_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			copy_v_s1 <= (state_q == BK_COPY) && (addr_q < 11'(cmd_q.plen));
			crc_v_s1 <= (state_q == BK_CRC) && (addr_q < total_q);
			case (state_q)
				BK_CLEAR: begin
					addr_q <= (state_d == BK_CLEAR) ? addr_q + 11'd1 : 11'd0;
					if (state_d != BK_CLEAR) begin
						full_clear_q <= 1'b0;
					end
				end
				BK_IDLE: begin
					addr_q <= 11'd0;
					if (q_valid && q_cmd.kind == CMD_REJECT) begin
						done_q <= 1'b1;
					end
					if (q_valid && q_cmd.kind == CMD_FRAME && new_assembly) begin
						cur_sender_q <= q_cmd.sender;
						cur_pid_q <= q_cmd.packet_id;
						cur_chk_q <= q_cmd.check;
						exp_q <= q_cmd.cnt;
						rcvd_q <= '0;
						fpl_q <= 8'd0;
						clear_to_copy_q <= 1'b1;
					end
				end
				BK_READ_WAIT: done_q <= 1'b1;
				BK_COPY: begin
					if (addr_q < 11'(cmd_q.plen)) begin
						addr_q <= addr_q + 11'd1;
					end
				end
				BK_TALLY: begin
					rcvd_q <= rcvd_new;
					fpl_q <= fpl_new;
					addr_q <= 11'd0;
					if (!complete) begin
						done_q <= 1'b1;
					end
				end
				BK_CRC: begin
					if (addr_q < total_q) begin
						addr_q <= addr_q + 11'd1;
					end
				end
				BK_CHECK: begin
					done_q <= 1'b1;
					addr_q <= 11'd0;
					clear_to_copy_q <= 1'b0;
					cur_sender_q <= 32'd0;
					cur_pid_q <= 32'd0;
					cur_chk_q <= 16'd0;
					exp_q <= 7'd0;
					rcvd_q <= '0;
					fpl_q <= 8'd0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid) begin
			cmd_q <= q_cmd;
		end
		copy_a_s1 <= 10'(cmd_q.off + addr_q);
		if (state_q == BK_TALLY) begin
			total_q <= total_new;
			crc_q <= CRC_INIT;
		end else if (crc_v_s1) begin
			crc_q <= crc_byte(crc_q, mem_rdata);
		end
		result_q <= '0;
		case (state_q)
			BK_IDLE: result_q.status <= ST_REJECT;
			BK_READ_WAIT: begin
				result_q.status <= ST_READ;
				result_q.read_data <= mem_rdata;
			end
			BK_TALLY: result_q.status <= ST_STORED;
			BK_CHECK: begin
				if (crc_q == cur_chk_q) begin
					result_q.status <= ST_COMPLETE;
					result_q.packet_length <= total_q;
					result_q.sender <= cur_sender_q;
					result_q.packet_id <= cur_pid_q;
				end else begin
					result_q.status <= ST_CRC_FAIL;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// File: hdl/fragment_reassembler_crc16_core.sv
// Top level of the fragment reassembler with CRC-16/CCITT-FALSE completion check.
// A frame byte without the end marker does not hold the intake. The final byte of a frame holds
// the intake until the back end has handled the frame: a validation step, then a commit that
// copies the payload into the packet store at one byte per cycle, and, when the last missing
// fragment arrives, a CRC pass that reads the store one byte per cycle. A fragment that starts
// a new assembly, and every completed or failed packet, sweeps the packet store clear one byte
// per cycle over the first min(1024, MAX_PIECES * PAYLOAD_BYTES) bytes; after reset the sweep
// covers all 1024 bytes. A read request passes through BK_IDLE and BK_READ_WAIT in the back
// end; up to two requests wait in the command queue. Each request that has a result gives it
// on result for exactly one cycle with done high, in request order, and the receiver cannot
// stall it.
`default_nettype none
module fragment_reassembler_crc16_core
	import frs_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 64,
	parameter int MAX_PIECES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire in_req_t    req,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	output logic            done,
	output result_t         result
);

	localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	logic          accept;
	logic          push;
	cmd_t          push_cmd;
	logic          hold;
	logic          q_valid;
	logic          q_full;
	cmd_t          q_head;
	logic          pop;
	logic [PW-1:0] buf_raddr;
	logic [7:0]    buf_rdata;
	logic          frame_done;

	assign busy = q_full || hold;
	assign accept = start && !busy;

	frs_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.MAX_PIECES(MAX_PIECES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.accept(accept),
		.req(req),
		.frame_done(frame_done),
		.buf_raddr(buf_raddr),
		.buf_rdata(buf_rdata),
		.push(push),
		.push_cmd(push_cmd),
		.hold(hold)
	);

	frs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.valid(q_valid),
		.full(q_full),
		.head(q_head)
	);

	frs_back #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.MAX_PIECES(MAX_PIECES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(q_head),
		.buf_rdata(buf_rdata),
		.pop(pop),
		.buf_raddr(buf_raddr),
		.frame_done(frame_done),
		.done(done),
		.result(result)
	);

endmodule
`default_nettype wire

// File: hdl/frs_checker.sv
// Port-level checker for the fragment reassembler and its bind to the top level.
`default_nettype none
module frs_checker
	import frs_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire in_req_t req,
	input wire logic    done,
	input wire result_t result
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_READ))
		else $error("Result status is out of range.");

	a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_READ) |-> (result.read_data == 8'h00))
		else $error("Read data is set on a frame result.");

	a_identity_only_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_COMPLETE) |->
		(result.packet_length == 11'd0 && result.sender == 32'd0 && result.packet_id == 32'd0))
		else $error("Packet fields are set on a result that is not complete.");

	a_frame_end_holds_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_FRAME && req.frame_end) |=> busy)
		else $error("Intake did not stall after the end of a frame.");

endmodule

bind fragment_reassembler_crc16_core frs_checker u_frs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.req(req),
	.done(done),
	.result(result)
);
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the fragment reassembler with CRC-16 completion check.
module tb_top;
	import frs_pkg::*;

	localparam int PAYLOAD = 64;
	localparam int PIECES = 16;
	localparam int STAGE = HEADER_BYTES + PAYLOAD;
	localparam int SETTLE_CYCLES = 2400;
	localparam int STALL_LIMIT = 20000;
	localparam int ITEM_TARGET = 1650;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_req_t    req = '0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_MAGIC_FIRST;
	logic [7:0] cfg_wdata = 8'h00;
	logic       done;
	result_t    result;

	fragment_reassembler_crc16_core #(
		.PAYLOAD_BYTES(PAYLOAD),
		.MAX_PIECES(PIECES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the block.
	logic [7:0]  magic0_reg = 8'h00;
	logic [7:0]  magic1_reg = 8'h00;
	logic [7:0]  version_reg = 8'h00;
	logic [7:0]  stage_mem [STAGE];
	int unsigned stage_count = 0;
	logic [7:0]  store_mem [STORE_BYTES];
	logic [31:0] asm_sender = '0;
	logic [31:0] asm_id = '0;
	logic [15:0] asm_check = '0;
	int unsigned asm_pieces = 0;
	logic [63:0] asm_bits = '0;
	int unsigned asm_final_len = 0;

	result_t     pending_results [$];
	int          error_count = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          stall_cycles = 0;

	// Packet under construction by the stimulus.
	logic [7:0]  image [STORE_BYTES];
	int unsigned piece_len [PIECES];
	logic [15:0] image_check;
	logic [7:0]  frame_q [$];

	initial begin
		foreach (stage_mem[i]) stage_mem[i] = 8'h00;
		foreach (store_mem[i]) store_mem[i] = 8'h00;
	end

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		r = c ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic void restart_assembly(input logic [31:0] snd, input logic [31:0] pid,
			input logic [15:0] chk, input int unsigned cnt);
		asm_sender = snd;
		asm_id = pid;
		asm_check = chk;
		asm_pieces = cnt & 32'h7f;
		asm_final_len = 0;
		asm_bits = '0;
		foreach (store_mem[i]) store_mem[i] = 8'h00;
	endfunction

	function automatic result_t frame_outcome(input int unsigned flen);
		result_t res;
		int unsigned idx, cnt, plen, off, total;
		logic [31:0] snd, pid;
		logic [15:0] chk, crc;
		logic [63:0] full;
		res = '0;
		res.status = ST_REJECT;
		if (flen < HEADER_BYTES || flen > STAGE) return res;
		if (stage_mem[0] != magic0_reg || stage_mem[1] != magic1_reg ||
				stage_mem[2] != version_reg) return res;
		idx = stage_mem[3];
		cnt = stage_mem[4];
		plen = stage_mem[5];
		snd = {stage_mem[9], stage_mem[8], stage_mem[7], stage_mem[6]};
		pid = {stage_mem[13], stage_mem[12], stage_mem[11], stage_mem[10]};
		chk = {stage_mem[15], stage_mem[14]};
		if (cnt == 0 || cnt > PIECES || idx >= cnt || plen > PAYLOAD ||
				flen != HEADER_BYTES + plen) return res;
		off = idx * PAYLOAD;
		if (off + plen > STORE_BYTES) return res;
		if (snd != asm_sender || pid != asm_id || chk != asm_check || cnt != asm_pieces)
			restart_assembly(snd, pid, chk, cnt);
		for (int i = 0; i < plen; i++) store_mem[off + i] = stage_mem[HEADER_BYTES + i];
		asm_bits[idx] = 1'b1;
		if (idx == cnt - 1) asm_final_len = plen;
		full = (64'd1 << cnt) - 64'd1;
		res.status = ST_STORED;
		if (asm_bits != full || asm_final_len == 0) return res;
		total = (cnt - 1) * PAYLOAD + asm_final_len;
		crc = 16'hffff;
		for (int i = 0; i < total; i++) crc = crc_step(crc, store_mem[i]);
		if (crc != asm_check) begin
			res.status = ST_CRC_FAIL;
		end else begin
			res.status = ST_COMPLETE;
			res.packet_length = total[10:0];
			res.sender = asm_sender;
			res.packet_id = asm_id;
		end
		restart_assembly('0, '0, '0, 0);
		return res;
	endfunction

	function automatic void predict_request(input in_req_t r);
		result_t res;
		res = '0;
		if (r.req_type == REQ_READ) begin
			res.status = ST_READ;
			res.read_data = store_mem[r.read_index];
			pending_results.push_back(res);
		end else begin
			if (stage_count < STAGE) stage_mem[stage_count] = r.data_byte;
			if (stage_count <= STAGE) stage_count++;
			if (r.frame_end) begin
				res = frame_outcome(stage_count);
				stage_count = 0;
				pending_results.push_back(res);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result status", result.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.status != want.status)
					report_mismatch("status", result.status, want.status);
				if (result.packet_length != want.packet_length)
					report_mismatch("packet_length", result.packet_length, want.packet_length);
				if (result.sender != want.sender)
					report_mismatch("sender", result.sender, want.sender);
				if (result.packet_id != want.packet_id)
					report_mismatch("packet_id", result.packet_id, want.packet_id);
				if (result.read_data != want.read_data)
					report_mismatch("read_data", result.read_data, want.read_data);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Sends one request; the sender idles between bursts of random length.
	task automatic send_item(input in_req_t r);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predict_request(r);
		items_sent++;
	endtask

	task automatic send_read(input int unsigned index);
		in_req_t r;
		r.req_type = REQ_READ;
		r.data_byte = $urandom_range(0, 255);
		r.frame_end = $urandom_range(0, 1);
		r.read_index = index[9:0];
		send_item(r);
	endtask

	task automatic send_frame();
		in_req_t r;
		foreach (frame_q[i]) begin
			r.req_type = REQ_FRAME;
			r.data_byte = frame_q[i];
			r.frame_end = (i == frame_q.size() - 1);
			r.read_index = $urandom_range(0, 1023);
			send_item(r);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] ver);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_MAGIC_FIRST;
		cfg_wdata <= m0;
		@(posedge clk);
		magic0_reg = m0;
		cfg_index <= REG_MAGIC_SECOND;
		cfg_wdata <= m1;
		@(posedge clk);
		magic1_reg = m1;
		cfg_index <= REG_FORMAT_VERSION;
		cfg_wdata <= ver;
		@(posedge clk);
		version_reg = ver;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Builds a frame with the given header fields and payload taken from the image.
	task automatic build_frame(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] ver,
			input logic [7:0] idx, input logic [7:0] cnt, input logic [7:0] plen,
			input logic [31:0] snd, input logic [31:0] pid, input logic [15:0] chk,
			input int unsigned body);
		frame_q = {m0, m1, ver, idx, cnt, plen, snd[7:0], snd[15:8], snd[23:16], snd[31:24],
			pid[7:0], pid[15:8], pid[23:16], pid[31:24], chk[7:0], chk[15:8]};
		for (int i = 0; i < body; i++)
			frame_q.push_back(image[(idx % PIECES) * PAYLOAD + (i % PAYLOAD)]);
	endtask

	task automatic fill_image(input int unsigned cnt, input int unsigned longest);
		int unsigned total;
		foreach (image[i]) image[i] = 8'h00;
		for (int p = 0; p < cnt; p++) begin
			piece_len[p] = (p == cnt - 1) ? $urandom_range(1, longest) :
				$urandom_range(0, longest);
			for (int i = 0; i < piece_len[p]; i++) image[p * PAYLOAD + i] = $urandom_range(0, 255);
		end
		total = (cnt - 1) * PAYLOAD + piece_len[cnt - 1];
		image_check = 16'hffff;
		for (int i = 0; i < total; i++) image_check = crc_step(image_check, image[i]);
	endtask

	// Sends the pieces of the image in random order; a mode may damage or cut the packet.
	task automatic send_packet(input int unsigned cnt, input int unsigned mode);
		logic [31:0] snd, pid;
		int order [$];
		int pick, victim;
		snd = $urandom();
		pid = $urandom();
		for (int p = 0; p < cnt; p++) order.push_back(p);
		order.shuffle();
		if (mode == 2 && cnt > 1) void'(order.pop_back());
		victim = $urandom_range(0, cnt - 1);
		foreach (order[k]) begin
			pick = order[k];
			build_frame(magic0_reg, magic1_reg, version_reg, pick, cnt, piece_len[pick], snd, pid,
				image_check, piece_len[pick]);
			if (mode == 1 && pick == victim) begin
				if (piece_len[pick] > 0) frame_q[HEADER_BYTES] ^= 8'h01 << $urandom_range(0, 7);
				else frame_q[14] ^= 8'h80;
			end
			if ($urandom_range(0, 5) == 0 && k == 0) send_frame();
			send_frame();
			if ($urandom_range(0, 3) == 0) send_read(pick * PAYLOAD + $urandom_range(0, 7));
		end
	endtask

	task automatic test_reset_state();
		send_read(0);
		send_read(1023);
		fill_image(1, 4);
		send_packet(1, 0);
	endtask

	task automatic test_register_extremes();
		configure(8'hff, 8'hff, 8'hff);
		fill_image(2, 3);
		send_packet(2, 0);
		configure(8'h00, 8'hff, 8'h00);
		fill_image(1, 2);
		send_packet(1, 0);
		configure(8'h5a, 8'ha5, 8'h01);
	endtask

	task automatic test_header_checks();
		logic [7:0] m0, m1, v;
		m0 = magic0_reg;
		m1 = magic1_reg;
		v = version_reg;
		fill_image(1, 4);
		frame_q = {8'h12, 8'h34, 8'h56, 8'h78, 8'h9a};
		send_frame();
		build_frame(m0, m1, v, 0, 1, 0, 1, 2, 16'h0000, 0);
		repeat (STAGE + 5) frame_q.push_back($urandom_range(0, 255));
		send_frame();
		build_frame(~m0, m1, v, 0, 1, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, ~m1, v, 0, 1, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, m1, ~v, 0, 1, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, m1, v, 0, 0, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, m1, v, 0, PIECES + 1, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, m1, v, 255, 255, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, m1, v, 3, 3, 2, 1, 2, 3, 2);
		send_frame();
		build_frame(m0, m1, v, 0, 1, PAYLOAD + 1, 1, 2, 3, PAYLOAD + 1);
		send_frame();
		build_frame(m0, m1, v, 0, 1, 3, 1, 2, 3, 2);
		send_frame();
	endtask

	task automatic test_empty_final_piece();
		fill_image(2, 4);
		build_frame(magic0_reg, magic1_reg, version_reg, 1, 2, 0, 32'hffffffff, 32'hffffffff,
			16'hffff, 0);
		send_frame();
		build_frame(magic0_reg, magic1_reg, version_reg, 0, 2, 4, 32'hffffffff, 32'hffffffff,
			16'hffff, 4);
		send_frame();
		send_read(0);
		send_read(3);
	endtask

	task automatic test_crc_and_restart();
		fill_image(3, 4);
		send_packet(3, 1);
		fill_image(3, 4);
		send_packet(3, 2);
		fill_image(2, 4);
		send_packet(2, 0);
	endtask

	task automatic test_largest_packet();
		foreach (image[i]) image[i] = $urandom_range(0, 255);
		for (int p = 0; p < PIECES; p++) piece_len[p] = PAYLOAD;
		image_check = 16'hffff;
		foreach (image[i]) image_check = crc_step(image_check, image[i]);
		send_packet(PIECES, 0);
		send_read(1023);
	endtask

	task automatic test_random_traffic();
		int unsigned kind, cnt, rounds, n;
		rounds = 0;
		while (items_sent < ITEM_TARGET) begin
			rounds++;
			if (rounds % 15 == 0) begin
				case ($urandom_range(0, 2))
					0: configure(8'h00, 8'h00, 8'h00);
					1: configure(8'hff, 8'hff, 8'hff);
					default: configure($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				endcase
			end
			kind = $urandom_range(0, 9);
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(5, PIECES) : $urandom_range(1, 4);
			if (kind <= 5) begin
				fill_image(cnt, ($urandom_range(0, 7) == 0) ? PAYLOAD : 6);
				send_packet(cnt, 0);
			end else if (kind <= 7) begin
				fill_image(cnt, 6);
				send_packet(cnt, kind - 5);
			end else if (kind == 8) begin
				n = $urandom_range(0, 20);
				if (n < 16)
					build_frame(magic0_reg, magic1_reg, version_reg, $urandom_range(0, 20),
						$urandom_range(0, 20), $urandom_range(0, 70), $urandom(), $urandom(),
						$urandom(), $urandom_range(0, 70));
				else
					frame_q = {};
				repeat ($urandom_range(0, 3)) frame_q.push_back($urandom_range(0, 255));
				if (frame_q.size() == 0) frame_q.push_back($urandom_range(0, 255));
				send_frame();
			end else begin
				repeat ($urandom_range(1, 6)) send_read($urandom_range(0, 1023));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_extremes();
		test_header_checks();
		test_empty_final_piece();
		test_crc_and_restart();
		test_largest_packet();
		test_random_traffic();
		settle();
		if (error_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
